// File: rtl/protected_region_write_checker_top_defines.svh
// Assertion macros used by the top-level RTL file of the region write checker.
// Both macros sample on the rising edge of clk and are disabled while arst_n is low.
`ifndef PROTECTED_REGION_WRITE_CHECKER_TOP_DEFINES_SVH
`define PROTECTED_REGION_WRITE_CHECKER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication: when the condition holds, the consequence holds too.
`define PRWC_ASSERT_IMP(lbl, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication: when the condition holds, the consequence holds in the following cycle.
`define PRWC_ASSERT_NEXT(lbl, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error("assertion failed");
`else
`define PRWC_ASSERT_IMP(lbl, cond, cons)
`define PRWC_ASSERT_NEXT(lbl, cond, cons)
`endif

`endif

// File: rtl/prwc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package prwc_pkg;

	// Table depth and the widths that follow from it.
	localparam int MAX_REGIONS = 16;
	localparam int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int CNT_W       = $clog2(MAX_REGIONS + 1);

	// Command codes carried in the input item.
	typedef enum logic [1:0] {
		CMD_WATCH   = 2'd0,
		CMD_UNWATCH = 2'd1,
		CMD_CHECK   = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	// Status codes carried in the result item.
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_DENIED = 2'd1,
		ST_FULL   = 2'd2,
		ST_MISS   = 2'd3
	} status_t;

	// One table entry as held in the region memory.
	typedef struct packed {
		logic        active;
		logic [2:0]  level;
		logic [31:0] length;
		logic [31:0] base;
	} entry_t;

	// The reported index is the entry index taken modulo sixteen.
	function automatic logic [3:0] to_hit(input logic [IDX_W-1:0] idx);
		logic [IDX_W+3:0] wide;
		wide = {4'b0000, idx};
		return wide[3:0];
	endfunction

endpackage

`default_nettype wire

// File: rtl/protected_region_write_checker_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake         Payload
// s_*       in         s_tvalid/s_tready command, address, length, level (s_tdata)
// m_*       out        m_tvalid/m_tready status, hit_index, denial_total (m_tdata)
//
// A watch, an unknown command or any command on an empty table goes from acceptance
// straight to the response state, which loads the output register and raises m_tvalid.
// Unwatch and check walk one entry per cycle through the registered read and the single
// compare unit over at most sixteen entries; the next item is taken back in idle.
// A result waiting on m_tready holds the sequencer in its response state. Reset clears the
// fill count, the denial counter and all handshake state; the table needs no clearing.
`include "protected_region_write_checker_top_defines.svh"

module protected_region_write_checker_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// s_tdata, from bit 0: command[1:0], address[33:2], length[65:34], level[68:66], zero
	input  wire logic [71:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// m_tdata, from bit 0: status[1:0], hit_index[5:2], denial_total[37:6], zero
	output logic [39:0]      m_tdata
);

	import prwc_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WALK = 3'b010,
		S_RESP = 3'b100
	} state_t;

	state_t           state_q;
	cmd_t             cmd_q;
	logic [31:0]      addr_q;
	logic [31:0]      span_end_q;
	logic [2:0]       lvl_q;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0]      denial_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic [IDX_W-1:0] ev_idx_q;
	entry_t           rd_q;
	status_t          res_status_q;
	logic [3:0]       res_idx_q;
	logic             m_tvalid_q;
	logic [39:0]      m_tdata_q;

	entry_t           mem [MAX_REGIONS];

	logic             acc;
	cmd_t             in_cmd;
	logic [31:0]      in_addr;
	logic [31:0]      in_len;
	logic [2:0]       in_lvl;
	logic             tbl_full;
	logic [IDX_W-1:0] rd_addr;
	logic             mem_we;
	logic [IDX_W-1:0] mem_wa;
	entry_t           mem_wd;
	logic [31:0]      reg_end;
	logic             hit_chk;
	logic             hit_unw;
	logic             walk_hit;
	logic             ev_last;

	// Input unpacking and handshake.
	assign s_tready = (state_q == S_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign in_cmd   = cmd_t'(s_tdata[1:0]);
	assign in_addr  = s_tdata[33:2];
	assign in_len   = s_tdata[65:34];
	assign in_lvl   = s_tdata[68:66];
	assign tbl_full = (cnt_q == CNT_W'(MAX_REGIONS));

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Shared compare unit: evaluates the entry read in the previous cycle.
	assign reg_end  = rd_q.base + rd_q.length;
	assign hit_chk  = rd_q.active && (addr_q < reg_end) && (span_end_q > rd_q.base) &&
	                  (lvl_q > rd_q.level);
	assign hit_unw  = (rd_q.base == addr_q);
	assign walk_hit = (cmd_q == CMD_CHECK) ? hit_chk : hit_unw;
	assign ev_last  = ((CNT_W'(ev_idx_q) + CNT_W'(1)) == cnt_q);

	// Read address: entry zero while idle so that a walk starts at once.
	assign rd_addr = (state_q == S_IDLE) ? '0 : rd_idx_q;

	// Write port: appends on watch, clears the active mark on an unwatch hit.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = cnt_q[IDX_W-1:0];
		mem_wd = '{active: 1'b1, level: in_lvl, length: in_len, base: in_addr};
		if (acc && (in_cmd == CMD_WATCH) && !tbl_full) begin
			mem_we = 1'b1;
		end else if ((state_q == S_WALK) && (cmd_q == CMD_UNWATCH) && hit_unw) begin
			mem_we        = 1'b1;
			mem_wa        = ev_idx_q;
			mem_wd        = rd_q;
			mem_wd.active = 1'b0;
		end
	end

	// Region memory with registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
	end

	// Sequencer: accept, walk the table where the command needs it, then hand the result to the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			denial_q     <= '0;
			m_tvalid_q   <= 1'b0;
			rd_idx_q     <= '0;
			ev_idx_q     <= '0;
			cmd_q        <= CMD_NONE;
			addr_q       <= '0;
			span_end_q   <= '0;
			lvl_q        <= '0;
			res_status_q <= ST_OK;
			res_idx_q    <= '0;
			m_tdata_q    <= '0;
		end else begin
			// The response state reloads the output register itself.
			if (m_tvalid_q && m_tready && (state_q != S_RESP)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						cmd_q      <= in_cmd;
						addr_q     <= in_addr;
						span_end_q <= in_addr + in_len;
						lvl_q      <= in_lvl;
						ev_idx_q   <= '0;
						rd_idx_q   <= IDX_W'(1);
						res_idx_q  <= '0;
						state_q    <= S_RESP;
						case (in_cmd)
							CMD_WATCH: begin
								if (tbl_full) begin
									res_status_q <= ST_FULL;
								end else begin
									res_status_q <= ST_OK;
									res_idx_q    <= to_hit(cnt_q[IDX_W-1:0]);
									cnt_q        <= cnt_q + CNT_W'(1);
								end
							end
							CMD_UNWATCH: begin
								res_status_q <= ST_MISS;
								if (cnt_q != '0) begin
									state_q <= S_WALK;
								end
							end
							CMD_CHECK: begin
								res_status_q <= ST_OK;
								if (cnt_q != '0) begin
									state_q <= S_WALK;
								end
							end
							default: begin
								res_status_q <= ST_OK;
							end
						endcase
					end
				end
				S_WALK: begin
					if (walk_hit) begin
						res_idx_q <= to_hit(ev_idx_q);
						state_q   <= S_RESP;
						if (cmd_q == CMD_CHECK) begin
							res_status_q <= ST_DENIED;
							denial_q     <= denial_q + 32'd1;
						end else begin
							res_status_q <= ST_OK;
						end
					end else if (ev_last) begin
						state_q <= S_RESP;
					end else begin
						ev_idx_q <= ev_idx_q + IDX_W'(1);
						rd_idx_q <= rd_idx_q + IDX_W'(1);
					end
				end
				S_RESP: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {2'b00, denial_q, res_idx_q, res_status_q};
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The fill count never passes the table depth.
	`PRWC_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(MAX_REGIONS))
	// A watch into a table with room adds exactly one entry.
	`PRWC_ASSERT_NEXT(a_watch_adds, acc && (in_cmd == CMD_WATCH) && !tbl_full,
		cnt_q == CNT_W'($past(cnt_q) + CNT_W'(1)))
	// The denial counter moves only together with a denied result.
	`PRWC_ASSERT_IMP(a_denial_move, denial_q != $past(denial_q),
		(state_q == S_RESP) && (res_status_q == ST_DENIED))
	// The walk never evaluates an entry beyond the fill count.
	`PRWC_ASSERT_IMP(a_walk_range, state_q == S_WALK, CNT_W'(ev_idx_q) < cnt_q)

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import prwc_pkg::*;

	localparam int RANDOM_ITEMS = 1725;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam int IDLE_PCT     = 27;

	// One command as the stimulus sees it, with an optional hand-written answer.
	typedef struct {
		cmd_t        cmd;
		logic [31:0] addr;
		logic [31:0] len;
		logic [2:0]  lvl;
		bit          given;
		status_t     st;
		logic [3:0]  hit;
		logic [31:0] total;
	} access_row_t;

	// One answer of the block.
	typedef struct {
		status_t     st;
		logic [3:0]  hit;
		logic [31:0] total;
	} verdict_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;

	// Private copy of the region table and the denial counter.
	logic [31:0] tbl_base   [MAX_REGIONS];
	logic [31:0] tbl_length [MAX_REGIONS];
	logic [2:0]  tbl_level  [MAX_REGIONS];
	bit          tbl_active [MAX_REGIONS];
	int          tbl_fill;
	logic [31:0] denial_tally;

	access_row_t directed_rows[$];
	access_row_t rows_in_flight[$];
	verdict_t    pending_verdicts[$];
	int          status_seen[4];
	int          fault_count;
	int          items_taken;
	int          results_checked;
	int          stall_cycles;
	bit          steady_stretch;

	protected_region_write_checker_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #4 clk = ~clk;

	// Builds one stimulus row.
	function automatic access_row_t mk_row(cmd_t cmd, logic [31:0] addr, logic [31:0] len,
		logic [2:0] lvl, bit given = 0, status_t st = ST_OK, logic [3:0] hit = '0,
		logic [31:0] total = '0);
		access_row_t r;
		r.cmd   = cmd;
		r.addr  = addr;
		r.len   = len;
		r.lvl   = lvl;
		r.given = given;
		r.st    = st;
		r.hit   = hit;
		r.total = total;
		return r;
	endfunction

	// Applies one command to the private table and returns the answer it should give.
	function automatic verdict_t predict_region_access(cmd_t cmd, logic [31:0] addr,
		logic [31:0] len, logic [2:0] lvl);
		verdict_t    v;
		bit          found;
		logic [31:0] span_end;
		logic [31:0] reg_end;
		v.st  = ST_OK;
		v.hit = '0;
		found = 0;
		case (cmd)
			CMD_WATCH: begin
				if (tbl_fill >= MAX_REGIONS) begin
					v.st = ST_FULL;
				end else begin
					tbl_base[tbl_fill]   = addr;
					tbl_length[tbl_fill] = len;
					tbl_level[tbl_fill]  = lvl;
					tbl_active[tbl_fill] = 1;
					v.hit                = 4'(tbl_fill);
					tbl_fill++;
				end
			end
			CMD_UNWATCH: begin
				v.st = ST_MISS;
				for (int k = 0; k < tbl_fill; k++) begin
					if (!found && tbl_base[k] == addr) begin
						tbl_active[k] = 0;
						v.st          = ST_OK;
						v.hit         = 4'(k);
						found         = 1;
					end
				end
			end
			CMD_CHECK: begin
				span_end = addr + len;
				for (int k = 0; k < tbl_fill; k++) begin
					reg_end = tbl_base[k] + tbl_length[k];
					if (!found && tbl_active[k] && addr < reg_end && span_end > tbl_base[k]
						&& lvl > tbl_level[k]) begin
						denial_tally = denial_tally + 32'd1;
						v.st         = ST_DENIED;
						v.hit        = 4'(k);
						found        = 1;
					end
				end
			end
			default: begin
			end
		endcase
		v.total = denial_tally;
		return v;
	endfunction

	// Draws one random command; most are checks, and most checks are aimed at region edges.
	function automatic access_row_t draw_random_row();
		access_row_t r;
		int          pick;
		int          k;
		logic [31:0] offs;
		pick = $urandom_range(99);
		k    = $urandom_range(MAX_REGIONS - 1);
		offs = 32'($urandom_range(64)) - 32'd32;
		if (pick < 78) begin
			r = mk_row(CMD_CHECK, $urandom, $urandom, 3'($urandom_range(7)));
			case ($urandom_range(4))
				0: r.addr = tbl_base[k] + offs;
				1: r.addr = tbl_base[k] + tbl_length[k] + offs;
				2: r.addr = tbl_base[k] - 32'($urandom_range(256));
				default: begin
				end
			endcase
			if ($urandom_range(2) != 0)
				r.len = 32'($urandom_range(300));
		end else if (pick < 86) begin
			r = mk_row(CMD_UNWATCH, $urandom, $urandom, 3'($urandom_range(7)));
			// Only a few bases are ever released, so most of the table stays armed.
			if ($urandom_range(2) == 0)
				r.addr = tbl_base[($urandom_range(4) == 4) ? 8 : $urandom_range(3)];
		end else if (pick < 94) begin
			r = mk_row(CMD_WATCH, $urandom, $urandom, 3'($urandom_range(7)));
		end else begin
			r = mk_row(CMD_NONE, $urandom, $urandom, 3'($urandom_range(7)));
		end
		return r;
	endfunction

	// Counts a failure; only the first few are described.
	task automatic note_fault(string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// Offers one item on the input side, at times with a random gap in front of it.
	task automatic send_item(access_row_t r);
		if (!steady_stretch && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		rows_in_flight.push_back(r);
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, r.lvl, r.len, r.addr, r.cmd};
		do @(posedge clk); while (!s_tready);
	endtask

	// Each accepted item is run through the predictor.
	always @(posedge clk) begin
		access_row_t r;
		verdict_t    v;
		if (arst_n && s_tvalid && s_tready) begin
			r = rows_in_flight.pop_front();
			v = predict_region_access(cmd_t'(s_tdata[1:0]), s_tdata[33:2], s_tdata[65:34],
				s_tdata[68:66]);
			if (r.given) begin
				v.st    = r.st;
				v.hit   = r.hit;
				v.total = r.total;
			end
			pending_verdicts.push_back(v);
			items_taken++;
		end
	end

	// Each accepted result is compared with the oldest outstanding answer.
	always @(posedge clk) begin
		verdict_t v;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_verdicts.size() == 0) begin
				note_fault($sformatf("unexpected result %h", m_tdata));
			end else begin
				v = pending_verdicts.pop_front();
				results_checked++;
				status_seen[v.st]++;
				if (m_tdata[1:0] !== v.st || m_tdata[5:2] !== v.hit || m_tdata[37:6] !== v.total)
					note_fault($sformatf(
						"status %0d/%0d hit_index %0d/%0d denial_total %0d/%0d (exp/got)",
						v.st, m_tdata[1:0], v.hit, m_tdata[5:2], v.total, m_tdata[37:6]));
			end
		end
	end

	// The result side stalls at random except during the steady stretch.
	always @(posedge clk) begin
		m_tready <= steady_stretch || ($urandom_range(99) >= IDLE_PCT);
	end

	// Ends the run when no item moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles == STALL_LIMIT) begin
				$display("protected_region_write_checker_top regression: fail");
				$finish;
			end
		end
	end

	initial begin
		clk            = 1'b0;
		arst_n         <= 1'b0;
		s_tvalid       <= 1'b0;
		s_tdata        <= '0;
		m_tready       <= 1'b0;
		steady_stretch = 0;
		tbl_fill       = 0;
		denial_tally   = '0;
		fault_count    = 0;
		items_taken    = 0;
		results_checked = 0;

		// Empty table: a miss, an approved all-ones write, and an unknown command.
		directed_rows.push_back(mk_row(CMD_UNWATCH, 32'h0, 32'h0, 3'd0, 1, ST_MISS));
		directed_rows.push_back(mk_row(CMD_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 1, ST_OK));
		directed_rows.push_back(mk_row(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 1, ST_OK));
		// Fill the table: wrapping ends, empty and whole-space regions, a repeated base.
		directed_rows.push_back(mk_row(CMD_WATCH, 32'h0000_0000, 32'h0000_1000, 3'd0, 1, ST_OK, 0));
		directed_rows.push_back(mk_row(CMD_WATCH, 32'hFFFF_F000, 32'h0000_2000, 3'd7, 1, ST_OK, 1));
		directed_rows.push_back(mk_row(CMD_WATCH, 32'h1000_0000, 32'h0000_0000, 3'd3, 1, ST_OK, 2));
		directed_rows.push_back(mk_row(CMD_WATCH, 32'h2000_0000, 32'h0010_0000, 3'd1, 1, ST_OK, 3));
		directed_rows.push_back(mk_row(CMD_WATCH, 32'h2008_0000, 32'h0010_0000, 3'd2, 1, ST_OK, 4));
		directed_rows.push_back(mk_row(CMD_WATCH, 32'h4000_0000, 32'hFFFF_FFFF, 3'd6, 1, ST_OK, 5));
		directed_rows.push_back(mk_row(CMD_WATCH, 32'h8000_0000, 32'h0000_1000, 3'd0, 1, ST_OK, 6));
		directed_rows.push_back(mk_row(CMD_WATCH, 32'h8000_0800, 32'h0000_1000, 3'd4, 1, ST_OK, 7));
		directed_rows.push_back(mk_row(CMD_WATCH, 32'hA000_0000, 32'h0000_0100, 3'd5, 1, ST_OK, 8));
		directed_rows.push_back(mk_row(CMD_WATCH, 32'hC000_0000, 32'h0100_0000, 3'd0, 1, ST_OK, 9));
		directed_rows.push_back(mk_row(CMD_WATCH, 32'hDEAD_0000, 32'h0001_0000, 3'd3, 1, ST_OK, 10));
		directed_rows.push_back(mk_row(CMD_WATCH, 32'h0000_0FFF, 32'h0000_0001, 3'd2, 1, ST_OK, 11));
		directed_rows.push_back(mk_row(CMD_WATCH, 32'hA000_0000, 32'h0000_0200, 3'd1, 1, ST_OK, 12));
		directed_rows.push_back(mk_row(CMD_WATCH, 32'h7FFF_FFFF, 32'h0000_0002, 3'd0, 1, ST_OK, 13));
		directed_rows.push_back(mk_row(CMD_WATCH, 32'hF000_0000, 32'h0800_0000, 3'd5, 1, ST_OK, 14));
		directed_rows.push_back(mk_row(CMD_WATCH, 32'h5555_5554, 32'hAAAA_AAAA, 3'd4, 1, ST_OK, 15));
		// A full table refuses further regions.
		directed_rows.push_back(mk_row(CMD_WATCH, 32'h1234_5678, 32'h10, 3'd2, 1, ST_FULL));
		// Denial at the first entry, release of a shared base twice, an empty write span.
		directed_rows.push_back(mk_row(CMD_CHECK, 32'h0000_0000, 32'h0000_0010, 3'd7));
		directed_rows.push_back(mk_row(CMD_UNWATCH, 32'hA000_0000, 32'h0, 3'd0));
		directed_rows.push_back(mk_row(CMD_UNWATCH, 32'hA000_0000, 32'h0, 3'd0));
		directed_rows.push_back(mk_row(CMD_CHECK, 32'h8000_0000, 32'h0000_0000, 3'd7));
		directed_rows.push_back(mk_row(CMD_CHECK, 32'hA000_0080, 32'h0000_0010, 3'd7));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i]);

		// Random part, with a stretch in the middle where neither side idles.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			steady_stretch = (n >= 800 && n < 1100);
			send_item(draw_random_row());
		end
		steady_stretch = 0;
		s_tvalid <= 1'b0;

		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		foreach (pending_verdicts[i])
			note_fault("answer still outstanding at the end");

		$display("Covered %0d items, %0d results: %0d approved, %0d denied, %0d full, %0d missed.",
			items_taken, results_checked, status_seen[ST_OK], status_seen[ST_DENIED],
			status_seen[ST_FULL], status_seen[ST_MISS]);
		$display("Final denial count %0d, %0d failures.", denial_tally, fault_count);
		if (fault_count == 0)
			$display("protected_region_write_checker_top regression: pass");
		else
			$display("protected_region_write_checker_top regression: fail");
		$finish;
	end

endmodule
